>>> rtl/sjgal_pkg.sv
// ----------------------------------------------------------------------------
// sjgal_pkg: shared types and tables for the glyph address lookup
// Holds the font descriptor table, the half-width kana conversion table,
// the code constants and the structs passed between the lookup modules.
// ----------------------------------------------------------------------------
package sjgal_pkg;

  // Defaults for the top-level parameters.
  localparam int SIZE_CLASSES_DEF = 7;
  localparam int ADDRESS_BITS_DEF = 21;

  // Fixed field widths.
  localparam int CODE_W  = 16;
  localparam int ADDR_W  = 21;
  localparam int INDEX_W = 13;
  localparam int BYTES_W = 7;
  localparam int FONT_W  = 4;
  localparam int SIZE_W  = 3;

  localparam int FONT_ROWS   = 14;
  localparam int FULL_OFFSET = 7;

  // Character code constants.
  localparam logic [CODE_W-1:0] KANA_FIRST     = 16'h00A1;
  localparam logic [CODE_W-1:0] KANA_LAST      = 16'h00DF;
  localparam logic [CODE_W-1:0] SINGLE_LIMIT   = 16'h0100;
  localparam logic [CODE_W-1:0] NOT_FOUND_WORD = 16'hFFFF;

  // Input item actions.
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_READ  = 1'b1
  } action_t;

  // Result kinds.
  typedef enum logic {
    KIND_REQUEST = 1'b0,
    KIND_DONE    = 1'b1
  } kind_t;

  // One row of the font descriptor table.
  typedef struct packed {
    logic [ADDR_W-1:0]  index_base;
    logic [ADDR_W-1:0]  data_base;
    logic [INDEX_W-1:0] count;
    logic [BYTES_W-1:0] bytes;
  } font_row_t;

  localparam font_row_t FONT_TABLE [FONT_ROWS] = '{
    '{21'h000000, 21'h00017E, 13'h00BF, 7'd8},
    '{21'h000776, 21'h000976, 13'h0100, 7'd10},
    '{21'h001376, 21'h001576, 13'h0100, 7'd12},
    '{21'h002176, 21'h002330, 13'h00DD, 7'd14},
    '{21'h002F46, 21'h003100, 13'h00DD, 7'd16},
    '{21'h003ED0, 21'h00404C, 13'h00BE, 7'd40},
    '{21'h005DFC, 21'h005FB6, 13'h00DD, 7'd48},
    '{21'h008926, 21'h00BEE4, 13'h1ADF, 7'd8},
    '{21'h0195DC, 21'h01CB96, 13'h1ADD, 7'd20},
    '{21'h03E4DA, 21'h041A98, 13'h1ADF, 7'd24},
    '{21'h069F80, 21'h06D53E, 13'h1ADF, 7'd28},
    '{21'h09C5A2, 21'h09FB60, 13'h1ADF, 7'd32},
    '{21'h0D5740, 21'h0D8CFE, 13'h1ADF, 7'd60},
    '{21'h13D942, 21'h140EFC, 13'h1ADD, 7'd72}
  };

  // Full-width codes for half-width kana 0xA1..0xDF. The last entry pads the
  // table to a power of two and is never selected.
  localparam logic [CODE_W-1:0] KANA_FULL [64] = '{
    16'h8142,
    16'h8175, 16'h8176, 16'h8141, 16'h8145, 16'h8392, 16'h8340, 16'h8342, 16'h8344,
    16'h8346, 16'h8348, 16'h8383, 16'h8385, 16'h8387, 16'h8362, 16'h815B, 16'h8341,
    16'h8343, 16'h8345, 16'h8347, 16'h8349, 16'h834A, 16'h834C, 16'h834E, 16'h8350,
    16'h8352, 16'h8354, 16'h8356, 16'h8358, 16'h835A, 16'h835C, 16'h835E, 16'h8360,
    16'h8363, 16'h8365, 16'h8367, 16'h8369, 16'h836A, 16'h836B, 16'h836C, 16'h836D,
    16'h836E, 16'h8371, 16'h8374, 16'h8377, 16'h837A, 16'h837D, 16'h837E, 16'h8380,
    16'h8381, 16'h8382, 16'h8384, 16'h8386, 16'h8388, 16'h8389, 16'h838A, 16'h838B,
    16'h838C, 16'h838D, 16'h838F, 16'h8393, 16'h814A, 16'h814B,
    16'h0000
  };

  // Font row lookup; rows past the table end fall back to the last row.
  function automatic font_row_t font_row(input logic [FONT_W-1:0] sel);
    font_row_t row;
    if (sel < FONT_W'(FONT_ROWS)) begin
      row = FONT_TABLE[sel];
    end else begin
      row = FONT_TABLE[FONT_ROWS-1];
    end
    return row;
  endfunction

  // Search state carried from one item to the next.
  typedef struct packed {
    logic               busy;
    logic [FONT_W-1:0]  font_select;
    logic [CODE_W-1:0]  target_code;
    logic [INDEX_W-1:0] low_bound;
    logic [INDEX_W-1:0] high_bound;
    logic [INDEX_W-1:0] probe;
  } search_state_t;

  // One input item.
  typedef struct packed {
    logic              action;
    logic [CODE_W-1:0] char_code;
    logic [CODE_W-1:0] read_word;
    logic              read_ok;
  } item_t;

  // One result item.
  typedef struct packed {
    logic               kind;
    logic [ADDR_W-1:0]  read_address;
    logic               found;
    logic [ADDR_W-1:0]  glyph_address;
    logic [BYTES_W-1:0] glyph_bytes;
    logic [FONT_W-1:0]  font_number;
    logic [INDEX_W-1:0] glyph_index;
  } result_t;

endpackage

>>> rtl/sjgal_if.sv
// ----------------------------------------------------------------------------
// sjgal_if: valid/ready channels of the glyph address lookup
// sjgal_in_if carries lookup starts and read answers, sjgal_out_if carries
// read requests and finished lookups.
// ----------------------------------------------------------------------------
interface sjgal_in_if
  import sjgal_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              action;
  logic [CODE_W-1:0] char_code;
  logic [CODE_W-1:0] read_word;
  logic              read_ok;

  modport source(output valid, action, char_code, read_word, read_ok, input ready);
  modport sink(input valid, action, char_code, read_word, read_ok, output ready);
endinterface

interface sjgal_out_if
  import sjgal_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [ADDR_W-1:0]  read_address;
  logic               found;
  logic [ADDR_W-1:0]  glyph_address;
  logic [BYTES_W-1:0] glyph_bytes;
  logic [FONT_W-1:0]  font_number;
  logic [INDEX_W-1:0] glyph_index;

  modport source(output valid, kind, read_address, found, glyph_address, glyph_bytes,
                 font_number, glyph_index, input ready);
  modport sink(input valid, kind, read_address, found, glyph_address, glyph_bytes,
               font_number, glyph_index, output ready);
endinterface

>>> rtl/sjgal_step.sv
// ----------------------------------------------------------------------------
// sjgal_step: one step of the glyph index binary search
// Combinational next state and result for one input item: font selection on
// a start, one probe comparison on a read answer, and the address math.
// ----------------------------------------------------------------------------
module sjgal_step
  import sjgal_pkg::*;
#(
  parameter int SIZE_CLASSES = SIZE_CLASSES_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic [SIZE_W-1:0] size_index,
  input  item_t             item,
  input  search_state_t     state,
  output search_state_t     state_next,
  output logic              emit,
  output result_t           result
);

  logic [SIZE_W-1:0]          size_sel;
  logic [CODE_W-1:0]          code;
  logic [5:0]                 kana_offset;
  logic                       full_width;
  logic [FONT_W-1:0]          start_font;
  logic [INDEX_W-1:0]         low_step;
  logic [INDEX_W-1:0]         high_step;
  logic                       request;
  logic                       done;
  logic                       hit;
  font_row_t                  row;
  font_row_t                  start_row;
  logic [INDEX_W:0]           span;
  logic [INDEX_W-1:0]         probe_sum;
  logic [INDEX_W+BYTES_W-1:0] glyph_offset;
  logic [ADDRESS_BITS-1:0]    index_addr;
  logic [ADDRESS_BITS-1:0]    glyph_addr;

  // Font selection for a new lookup, with kana mapped to full width.
  always_comb begin
    size_sel = size_index;
    if ({1'b0, size_index} >= (SIZE_W + 1)'(SIZE_CLASSES)) begin
      size_sel = SIZE_W'(SIZE_CLASSES - 1);
    end
    kana_offset = 6'(item.char_code - KANA_FIRST);
    code        = item.char_code;
    full_width  = (item.char_code >= SINGLE_LIMIT);
    if (item.char_code >= KANA_FIRST && item.char_code <= KANA_LAST) begin
      code       = KANA_FULL[kana_offset];
      full_width = 1'b1;
    end
    start_font = full_width ? ({1'b0, size_sel} + FONT_W'(FULL_OFFSET))
                            : {1'b0, size_sel};
    start_row  = font_row(start_font);
  end

  // Search control: start, compare against the probed word, narrow the range.
  always_comb begin
    state_next = state;
    request    = 1'b0;
    done       = 1'b0;
    hit        = 1'b0;
    low_step   = state.probe + INDEX_W'(1);
    high_step  = state.probe - INDEX_W'(1);
    if (item.action == ACT_START) begin
      state_next.busy        = 1'b1;
      state_next.font_select = start_font;
      state_next.target_code = code;
      state_next.low_bound   = '0;
      state_next.high_bound  = start_row.count - INDEX_W'(1);
      request                = 1'b1;
    end else if (state.busy) begin
      if (!item.read_ok || item.read_word == NOT_FOUND_WORD) begin
        done = 1'b1;
      end else if (item.read_word == state.target_code) begin
        done = 1'b1;
        hit  = 1'b1;
      end else if (state.target_code > item.read_word) begin
        state_next.low_bound = low_step;
        if (low_step > state.high_bound) begin
          done = 1'b1;
        end else begin
          request = 1'b1;
        end
      end else if (state.probe == '0) begin
        // Target below the first entry: stop before the bound wraps.
        done = 1'b1;
      end else begin
        state_next.high_bound = high_step;
        if (high_step < state.low_bound) begin
          done = 1'b1;
        end else begin
          request = 1'b1;
        end
      end
      if (done) begin
        state_next.busy = 1'b0;
      end
    end
    // The next probe sits in the middle of the remaining range, rounded up.
    span      = {1'b0, state_next.high_bound} - {1'b0, state_next.low_bound}
                + (INDEX_W + 1)'(1);
    probe_sum = state_next.low_bound + INDEX_W'(span >> 1);
    if (request) begin
      state_next.probe = probe_sum;
    end
  end

  // Addresses for the request or the finished lookup.
  always_comb begin
    row          = font_row(state_next.font_select);
    glyph_offset = (INDEX_W + BYTES_W)'(state.probe) * (INDEX_W + BYTES_W)'(row.bytes);
    index_addr   = ADDRESS_BITS'(row.index_base)
                   + ADDRESS_BITS'({state_next.probe, 1'b0});
    glyph_addr   = ADDRESS_BITS'(row.data_base) + ADDRESS_BITS'(glyph_offset);
  end

  // Result item.
  always_comb begin
    emit   = request || done;
    result = '0;
    result.font_number = state_next.font_select;
    if (done) begin
      result.kind        = KIND_DONE;
      result.found       = hit;
      result.glyph_bytes = row.bytes;
      if (hit) begin
        result.glyph_address = glyph_addr[ADDR_W-1:0];
        result.glyph_index   = state.probe;
      end
    end else begin
      result.kind         = KIND_REQUEST;
      result.read_address = index_addr[ADDR_W-1:0];
    end
  end

endmodule

>>> rtl/sjis_glyph_address_lookup.sv
// ----------------------------------------------------------------------------
// sjis_glyph_address_lookup: glyph bitmap address lookup by binary search
// Finds a character code in the sorted code index of the selected font and
// returns the address of its bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries input items. An item with action start begins a lookup of
//   char_code (a start during a running lookup replaces it). Each lookup
//   step produces a read request on res (kind 0) with the byte address of
//   one 16-bit index word; the user fetches that word and returns it on cmd
//   as an item with action read, read_word and read_ok. The lookup ends with
//   a kind 1 result giving found, glyph_address, glyph_bytes and glyph_index.
//   A read answer while no lookup runs causes no result.
//   cfg_we with cfg_data sets the font size class; write it only while idle.
// Timing:
//   Each cmd transfer lands in an input register; the step logic then loads
//   the result register from it once that register is free or draining,
//   and the result is offered on res until it is taken.
//   One item is taken every cycle unless res stalls; the throughput is set
//   by the single step logic stage between the two registers. A lookup needs
//   one read round trip per probe, at most 13 probes for the largest font.
// Reset and stall:
//   rst clears the search state, the size class and both register stages.
//   When res is stalled the result register holds; the input register keeps
//   any item it has, and cmd.ready then drops until the result is taken.
// ----------------------------------------------------------------------------
module sjis_glyph_address_lookup
  import sjgal_pkg::*;
#(
  parameter int SIZE_CLASSES = SIZE_CLASSES_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  sjgal_in_if.sink          cmd,
  sjgal_out_if.source       res,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data
);

  logic [SIZE_W-1:0] size_index;
  logic              stage_valid;
  item_t             stage_item;
  search_state_t     state;
  search_state_t     state_next;
  logic              emit;
  result_t           step_result;
  logic              out_valid;
  result_t           out_item;
  logic              advance;

  // The staged item moves on when the result register is free or draining.
  assign advance   = stage_valid && (!out_valid || res.ready);
  assign cmd.ready = !stage_valid || advance;

  // Size class register.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_index <= '0;
    end else if (cfg_we) begin
      size_index <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (cmd.ready) begin
      stage_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      stage_item <= '{action:    cmd.action,
                      char_code: cmd.char_code,
                      read_word: cmd.read_word,
                      read_ok:   cmd.read_ok};
    end
  end

  // Search step.
  sjgal_step #(
    .SIZE_CLASSES(SIZE_CLASSES),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_step (
    .size_index(size_index),
    .item      (stage_item),
    .state     (state),
    .state_next(state_next),
    .emit      (emit),
    .result    (step_result)
  );

  // Search state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_item <= step_result;
    end
  end

  assign res.valid         = out_valid;
  assign res.kind          = out_item.kind;
  assign res.read_address  = out_item.read_address;
  assign res.found         = out_item.found;
  assign res.glyph_address = out_item.glyph_address;
  assign res.glyph_bytes   = out_item.glyph_bytes;
  assign res.font_number   = out_item.font_number;
  assign res.glyph_index   = out_item.glyph_index;

endmodule

>>> rtl/sjgal_checker.sv
// ----------------------------------------------------------------------------
// sjgal_checker: port-level checks for the glyph address lookup
// Watches the channels of the top level and flags timing and handshake
// slips; attached to every instance of the top level by a bind.
// ----------------------------------------------------------------------------
module sjgal_checker
  import sjgal_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input logic               cmd_action,
  input logic               res_valid,
  input logic               res_ready,
  input logic               res_kind,
  input logic [ADDR_W-1:0]  res_read_address,
  input logic [ADDR_W-1:0]  res_glyph_address,
  input logic [INDEX_W-1:0] res_glyph_index
);

  // Reset empties the result register.
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // An empty result register never blocks the input side.
  assert property (@(posedge clk) disable iff (rst) !res_valid |-> cmd_ready)
    else $error("input stalled while result register is empty");

  // A start always yields a result when the receiver is ready while the start is staged.
  assert property (@(posedge clk) disable iff (rst)
                   (cmd_valid && cmd_ready && cmd_action == ACT_START) ##1 res_ready
                   |=> res_valid)
    else $error("start transfer produced no result");

  // A stalled result keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
                   res_valid && !res_ready |=> res_valid && $stable(res_kind)
                   && $stable(res_read_address) && $stable(res_glyph_address)
                   && $stable(res_glyph_index))
    else $error("stalled result changed");

endmodule

bind sjis_glyph_address_lookup sjgal_checker u_sjgal_checker (
  .clk              (clk),
  .rst              (rst),
  .cmd_valid        (cmd.valid),
  .cmd_ready        (cmd.ready),
  .cmd_action       (cmd.action),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_kind         (res.kind),
  .res_read_address (res.read_address),
  .res_glyph_address(res.glyph_address),
  .res_glyph_index  (res.glyph_index)
);

>>> bench/glyph_lookup_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_lookup_checker: result predictor and comparator for the lookup block
// Watches the cmd and res channels and the size class register writes. It
// keeps its own copy of the search state and computes the result that every
// cmd transfer causes. Each res transfer is then compared field by field
// with the oldest predicted result, and the mismatch count goes to the top.
// ----------------------------------------------------------------------------
module glyph_lookup_checker
  import sjgal_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  sjgal_in_if               cmd,
  sjgal_out_if              res,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data,
  output int                mismatch_count,
  output int                pending
);

  // Shadow copy of the size class register and the search state.
  logic [SIZE_W-1:0]  size_class;
  logic               searching;
  logic [FONT_W-1:0]  font_sel;
  logic [CODE_W-1:0]  wanted_code;
  logic [INDEX_W-1:0] lo_idx;
  logic [INDEX_W-1:0] hi_idx;
  logic [INDEX_W-1:0] probe_idx;

  // Predicted results in the order in which they must leave the block.
  result_t outstanding_replies[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  // Picks the middle of the remaining range and asks for that index word.
  task automatic issue_probe(output result_t r);
    logic [31:0] addr;
    probe_idx = INDEX_W'(int'(lo_idx) + ((int'(hi_idx) - int'(lo_idx) + 1) >>> 1));
    addr = 32'(FONT_TABLE[font_sel].index_base) + 32'(probe_idx) * 32'd2;
    r = '0;
    r.kind = KIND_REQUEST;
    r.read_address = addr[ADDR_W-1:0];
    r.font_number = font_sel;
  endtask

  // Ends the running search; the glyph address and index are filled in on a hit only.
  task automatic close_search(input bit hit, output result_t r);
    logic [31:0] addr;
    searching = 1'b0;
    addr = 32'(FONT_TABLE[font_sel].data_base)
         + 32'(probe_idx) * 32'(FONT_TABLE[font_sel].bytes);
    r = '0;
    r.kind = KIND_DONE;
    r.found = hit;
    r.glyph_bytes = FONT_TABLE[font_sel].bytes;
    r.font_number = font_sel;
    if (hit) begin
      r.glyph_address = addr[ADDR_W-1:0];
      r.glyph_index = probe_idx;
    end
  endtask

  // One search step for one accepted cmd item.
  task automatic search_step(input logic act, input logic [CODE_W-1:0] code_in,
                             input logic [CODE_W-1:0] word, input logic ok,
                             output bit produced, output result_t r);
    logic [CODE_W-1:0] code;
    logic [SIZE_W-1:0] cls;
    logic              wide;
    produced = 1'b1;
    r = '0;
    if (act == ACT_START) begin
      // A start always restarts, even in the middle of a running search.
      code = code_in;
      cls = (size_class >= SIZE_CLASSES_DEF) ? SIZE_W'(SIZE_CLASSES_DEF - 1) : size_class;
      wide = (code >= SINGLE_LIMIT);
      if (code >= KANA_FIRST && code <= KANA_LAST) begin
        code = KANA_FULL[6'(code - KANA_FIRST)];
        wide = 1'b1;
      end
      // Font rows stay within the table: classes are clamped to 0..6.
      font_sel = wide ? FONT_W'(cls) + FONT_W'(FULL_OFFSET) : FONT_W'(cls);
      wanted_code = code;
      searching = 1'b1;
      lo_idx = '0;
      hi_idx = FONT_TABLE[font_sel].count - 1'b1;
      issue_probe(r);
    end else if (!searching) begin
      produced = 1'b0;
    end else if (!ok || word == NOT_FOUND_WORD) begin
      close_search(1'b0, r);
    end else if (word == wanted_code) begin
      close_search(1'b1, r);
    end else if (wanted_code > word) begin
      lo_idx = probe_idx + 1'b1;
      if (lo_idx > hi_idx) begin
        close_search(1'b0, r);
      end else begin
        issue_probe(r);
      end
    end else if (probe_idx == '0) begin
      // Nothing below entry zero, so the search stops before the bound wraps.
      close_search(1'b0, r);
    end else begin
      hi_idx = probe_idx - 1'b1;
      if (hi_idx < lo_idx) begin
        close_search(1'b0, r);
      end else begin
        issue_probe(r);
      end
    end
  endtask

  initial begin
    mismatch_count = 0;
    pending = 0;
  end

  // Compare outgoing transfers first, then predict from the incoming one.
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    result_t next;
    bit      produced;
    if (rst) begin
      size_class = '0;
      searching = 1'b0;
      font_sel = '0;
      wanted_code = '0;
      lo_idx = '0;
      hi_idx = '0;
      probe_idx = '0;
      outstanding_replies.delete();
    end else begin
      if (res.valid && res.ready) begin
        seen.kind = res.kind;
        seen.read_address = res.read_address;
        seen.found = res.found;
        seen.glyph_address = res.glyph_address;
        seen.glyph_bytes = res.glyph_bytes;
        seen.font_number = res.font_number;
        seen.glyph_index = res.glyph_index;
        if (outstanding_replies.size() == 0) begin
          report_mismatch($sformatf("result of kind %0d with none predicted", seen.kind));
        end else begin
          want = outstanding_replies.pop_front();
          check_field("kind", 32'(seen.kind), 32'(want.kind));
          check_field("read_address", 32'(seen.read_address), 32'(want.read_address));
          check_field("found", 32'(seen.found), 32'(want.found));
          check_field("glyph_address", 32'(seen.glyph_address), 32'(want.glyph_address));
          check_field("glyph_bytes", 32'(seen.glyph_bytes), 32'(want.glyph_bytes));
          check_field("font_number", 32'(seen.font_number), 32'(want.font_number));
          check_field("glyph_index", 32'(seen.glyph_index), 32'(want.glyph_index));
        end
      end
      if (cmd.valid && cmd.ready) begin
        search_step(cmd.action, cmd.char_code, cmd.read_word, cmd.read_ok, produced, next);
        if (produced) begin
          outstanding_replies.push_back(next);
        end
      end
      if (cfg_we) begin
        size_class = cfg_data;
      end
    end
    pending = outstanding_replies.size();
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench top for the glyph address lookup
// Plays the index storage behind the block: every read request is answered
// from a synthetic sorted index, so searches run to hits, misses at both
// ends and misses between entries. Failed reads, end words, stray answers
// and restarts are mixed in, over all size classes, with random idling on
// both channels. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module tb_top
  import sjgal_pkg::*;
();

  localparam int ITEM_TARGET  = 2000;
  localparam int PHASES       = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int IDLE_PERCENT = 22;
  localparam int TOP_WORD     = 65534;

  // Ways in which one lookup is disturbed on purpose.
  typedef enum int {
    FLT_NONE       = 0,
    FLT_READ_ERROR = 1,
    FLT_END_WORD   = 2,
    FLT_GARBAGE    = 3,
    FLT_RESTART    = 4
  } fault_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_data;

  sjgal_in_if  cmd ();
  sjgal_out_if res ();

  int mismatch_count;
  int pending;

  // Read requests taken from res, waiting for an answer on cmd.
  logic [ADDR_W-1:0] request_addrs[$];
  logic [FONT_W-1:0] request_fonts[$];
  int                lookups_done;
  int                items_sent;
  int                stall_cycles;
  bit                no_idle;
  bit                search_open;

  logic [SIZE_W-1:0] phase_sizes [PHASES] = '{3'd3, 3'd0, 3'd6, 3'd7, 3'd1, 3'd5, 3'd2, 3'd4};

  sjis_glyph_address_lookup DUT (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .res      (res),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  glyph_lookup_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .res            (res),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // The result side stalls at random except in the steady phase.
  always @(negedge clk) begin
    res.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Collect read requests and count finished lookups.
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      if (res.kind == KIND_REQUEST) begin
        request_addrs.push_back(res.read_address);
        request_fonts.push_back(res.font_number);
      end else begin
        lookups_done++;
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("sjis_glyph_address_lookup verification failed");
      $finish;
    end
  end

  // Offers one item on cmd and returns at the edge where it transfers.
  task automatic put_cmd(input action_t act, input logic [CODE_W-1:0] code,
                         input logic [CODE_W-1:0] word, input logic ok,
                         input bit counted);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
      cmd.valid = 1'b0;
      @(negedge clk);
    end
    cmd.valid = 1'b1;
    cmd.action = act;
    cmd.char_code = code;
    cmd.read_word = word;
    cmd.read_ok = ok;
    do @(posedge clk); while (cmd.ready !== 1'b1);
    if (counted) begin
      items_sent++;
    end
  endtask

  // Waits for the next read request or for the end of the lookup.
  task automatic await_reply(input int mark);
    @(negedge clk);
    cmd.valid = 1'b0;
    while (request_addrs.size() == 0 && lookups_done == mark) begin
      @(negedge clk);
    end
  endtask

  // Waits until all predicted results are out and the pipeline is empty.
  task automatic drain();
    @(negedge clk);
    cmd.valid = 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] value);
    drain();
    cfg_we = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Runs one lookup against a synthetic index in which entry p holds
  // base + p * stride; the target sits at entry rank when shift is zero.
  task automatic lookup(input logic [CODE_W-1:0] code, input int rank, input int stride,
                        input int shift, input fault_t fault, input int fault_at);
    logic [CODE_W-1:0] target;
    logic [ADDR_W-1:0] addr;
    logic [FONT_W-1:0] font;
    int                base;
    int                entry;
    int                word;
    int                mark;
    int                probes;
    bit                ended;
    if (code >= KANA_FIRST && code <= KANA_LAST) begin
      target = KANA_FULL[6'(code - KANA_FIRST)];
    end else begin
      target = code;
    end
    base = int'(target) - rank * stride + shift;
    mark = lookups_done;
    search_open = 1'b0;
    put_cmd(ACT_START, code, 16'($urandom), 1'($urandom), 1'b1);
    probes = 0;
    ended = 1'b0;
    while (!ended) begin
      await_reply(mark);
      if (request_addrs.size() == 0) begin
        ended = 1'b1;
      end else begin
        addr = request_addrs.pop_front();
        font = request_fonts.pop_front();
        entry = (int'(addr) - int'(FONT_TABLE[font].index_base)) / 2;
        word = base + entry * stride;
        if (word < 0) begin
          word = 0;
        end
        if (word > TOP_WORD) begin
          word = TOP_WORD;
        end
        if (probes == fault_at && fault == FLT_RESTART) begin
          // Leave the request unanswered; the next start replaces the search.
          search_open = 1'b1;
          ended = 1'b1;
        end else if (probes == fault_at && fault == FLT_READ_ERROR) begin
          put_cmd(ACT_READ, 16'($urandom), 16'($urandom), 1'b0, 1'b1);
        end else if (probes == fault_at && fault == FLT_END_WORD) begin
          put_cmd(ACT_READ, 16'($urandom), NOT_FOUND_WORD, 1'b1, 1'b1);
        end else if (probes == fault_at && fault == FLT_GARBAGE) begin
          put_cmd(ACT_READ, 16'($urandom), 16'($urandom), 1'b1, 1'b1);
        end else begin
          put_cmd(ACT_READ, 16'($urandom), 16'(word), 1'b1, 1'b1);
        end
        probes++;
      end
    end
  endtask

  // Random lookup: code class, index shape and disturbance are all drawn.
  task automatic random_lookup(input bit may_fault);
    logic [CODE_W-1:0] code;
    int                roll;
    int                rank;
    int                stride;
    int                shift;
    fault_t            fault;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      // Half-width codes outside the kana range.
      code = 16'($urandom_range(0, 'hC0));
      if (code >= KANA_FIRST) begin
        code = code + 16'h3F;
      end
    end else if (roll < 45) begin
      code = 16'($urandom_range(KANA_FIRST, KANA_LAST));
    end else begin
      code = 16'($urandom_range(SINGLE_LIMIT, 'hFFFF));
    end
    stride = $urandom_range(1, 3);
    shift = (stride > 1 && $urandom_range(0, 3) == 0) ? 1 : 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      rank = $urandom_range(0, 189);
    end else if (roll < 80) begin
      rank = $urandom_range(0, 6876);
    end else if (roll < 90) begin
      rank = -int'($urandom_range(1, 40));
    end else begin
      rank = $urandom_range(200, 9000);
    end
    fault = FLT_NONE;
    if (may_fault && $urandom_range(0, 99) < 15) begin
      fault = fault_t'($urandom_range(FLT_READ_ERROR, FLT_RESTART));
    end
    lookup(code, rank, stride, shift, fault, $urandom_range(0, 10));
    // A stray answer while no search runs must be dropped by the block.
    if (!search_open && $urandom_range(0, 9) == 0) begin
      put_cmd(action_t'(ACT_READ), 16'($urandom), 16'($urandom), 1'($urandom), 1'b0);
    end
  endtask

  initial begin
    cmd.valid = 1'b0;
    cmd.action = ACT_START;
    cmd.char_code = '0;
    cmd.read_word = '0;
    cmd.read_ok = 1'b0;
    res.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    rst = 1'b1;
    no_idle = 1'b0;
    search_open = 1'b0;
    items_sent = 0;
    lookups_done = 0;
    stall_cycles = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: a read answer with no search running.
    put_cmd(ACT_READ, 16'hFFFF, 16'h0000, 1'b1, 1'b0);
    // Highest code with a failed read on the first probe.
    lookup(16'hFFFF, 0, 1, 0, FLT_READ_ERROR, 0);
    // First kana code answered with the end word.
    lookup(16'h00A1, 0, 1, 0, FLT_END_WORD, 0);
    // Last kana code, abandoned, then replaced by a start while busy.
    lookup(16'h00DF, 0, 1, 0, FLT_RESTART, 0);
    // Code zero below every entry: the search runs down to entry zero.
    lookup(16'h0000, -3, 1, 0, FLT_NONE, 0);
    // Out-of-range size class, target above every entry.
    write_size(3'd7);
    lookup(16'h00FF, 400, 2, 1, FLT_NONE, 0);

    // Random part over all size classes; one phase runs with no idling.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_size(phase_sizes[ph]);
      no_idle = (ph == 4);
      while (items_sent < ITEM_TARGET * (ph + 1) / PHASES) begin
        random_lookup(1'b1);
      end
      if (search_open) begin
        random_lookup(1'b0);
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("sjis_glyph_address_lookup verification clean");
    end else begin
      $display("sjis_glyph_address_lookup verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/sjgal_pkg.sv
rtl/sjgal_if.sv
rtl/sjgal_step.sv
rtl/sjis_glyph_address_lookup.sv
rtl/sjgal_checker.sv
bench/glyph_lookup_checker.sv
bench/tb_top.sv
